// ===== sv/mh64_pkg.sv =====
`default_nettype none
// ============================================================================
// mh64_pkg
// Shared constants and controller/datapath interface types for the
// MurmurHash64A block.
// ============================================================================
package mh64_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
    localparam int unsigned MIX_SHIFT = 47;

    // Operand feeding the shared multiply unit
    typedef enum logic [2:0] {
        OP_LEN  = 3'd0,   // message length, starts the accumulator
        OP_WORD = 3'd1,   // raw full word k
        OP_KMIX = 3'd2,   // k ^ (k >> 47)
        OP_ACCK = 3'd3,   // acc ^ k
        OP_PART = 3'd4,   // acc ^ masked partial word
        OP_FIN  = 3'd5    // acc ^ (acc >> 47)
    } mh_opsel_t;

    typedef struct packed {
        logic      load_in;    // capture input beat
        logic      mul_start;  // launch a multiply
        mh_opsel_t opsel;
        logic      acc_init;   // acc <= seed ^ product, open message
        logic      acc_prod;   // acc <= product
        logic      out_load;   // load finalized hash, close message
    } mh_cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic count_full;
        logic count_zero;
        logic in_msg;
        logic mul_idle;
        logic mul_done;
        logic out_free;
    } mh_status_t;

endpackage
`default_nettype wire

// ===== sv/mh64_mul.sv =====
`default_nettype none
// ============================================================================
// mh64_mul
// Iterative 64-bit multiply by the mix constant, low 64 bits of the product,
// one 32x32 partial product per cycle.
// ============================================================================
module mh64_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] operand,
    output logic [63:0]      product,
    output logic             idle,
    output logic             done
);
    import mh64_pkg::*;

    typedef enum logic [3:0] {
        MP_IDLE = 4'b0001,
        MP_LL   = 4'b0010,
        MP_LH   = 4'b0100,
        MP_HL   = 4'b1000
    } mp_phase_t;

    mp_phase_t   phase_reg, phase_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg;
    logic [63:0] p_reg, p_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] pp;

    always_comb
    begin
        case (phase_reg)
            MP_LL:
            begin
                mul_a = a_reg[31:0];
                mul_b = MIX_MUL_LO;
            end
            MP_LH:
            begin
                mul_a = a_reg[31:0];
                mul_b = MIX_MUL_HI;
            end
            MP_HL:
            begin
                mul_a = a_reg[63:32];
                mul_b = MIX_MUL_LO;
            end
            default:
            begin
                mul_a = a_reg[31:0];
                mul_b = MIX_MUL_LO;
            end
        endcase
    end

    assign pp = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        phase_next = phase_reg;
        p_next     = p_reg;
        done_next  = 1'b0;
        case (phase_reg)
            MP_IDLE:
            begin
                if (start)
                begin
                    phase_next = MP_LL;
                end
            end
            MP_LL:
            begin
                p_next     = pp;
                phase_next = MP_LH;
            end
            MP_LH:
            begin
                // cross terms only reach the upper half
                p_next[63:32] = p_reg[63:32] + pp[31:0];
                phase_next    = MP_HL;
            end
            MP_HL:
            begin
                p_next[63:32] = p_reg[63:32] + pp[31:0];
                phase_next    = MP_IDLE;
                done_next     = 1'b1;
            end
            default:
            begin
                phase_next = MP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (phase_reg == MP_IDLE))
        begin
            a_reg <= operand;
        end
        p_reg <= p_next;
    end

    assign product = p_reg;
    assign idle    = (phase_reg == MP_IDLE);
    assign done    = done_reg;

`ifndef NO_ASSERTIONS
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle) |-> ##4 done)
        else $error("multiply done not four cycles after start");
`endif

endmodule
`default_nettype wire

// ===== sv/mh64_datapath.sv =====
`default_nettype none
// ============================================================================
// mh64_datapath
// Input capture, seed and accumulator registers, operand selection for the
// multiply unit, and the hash output register.
// ============================================================================
module mh64_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mh64_pkg::mh_cmd_t cmd,
    output mh64_pkg::mh_status_t   st,
    input  wire logic [63:0]   data_word,
    input  wire logic [3:0]    byte_count,
    input  wire logic          first_item,
    input  wire logic          last_item,
    input  wire logic [30:0]   message_length,
    input  wire logic          cfg_valid,
    input  wire logic [31:0]   seed_value,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [63:0]        hash_value
);
    import mh64_pkg::*;

    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        first_reg;
    logic        last_reg;
    logic [30:0] len_reg;
    logic [31:0] seed_reg;
    logic [63:0] acc_reg;
    logic        in_msg_reg;
    logic [63:0] hash_reg;
    logic        out_valid_reg;

    logic [63:0] mask;
    logic [63:0] operand;
    logic [63:0] product;
    logic        mul_idle;
    logic        mul_done;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mask[8*i +: 8] = (4'(i) < count_reg) ? 8'hff : 8'h00;
        end
    end

    always_comb
    begin
        case (cmd.opsel)
            OP_LEN:  operand = {33'd0, len_reg};
            OP_WORD: operand = word_reg;
            OP_KMIX: operand = product ^ (product >> MIX_SHIFT);
            OP_ACCK: operand = acc_reg ^ product;
            OP_PART: operand = acc_reg ^ (word_reg & mask);
            OP_FIN:  operand = acc_reg ^ (acc_reg >> MIX_SHIFT);
            default: operand = word_reg;
        endcase
    end

    mh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .operand (operand),
        .product (product),
        .idle    (mul_idle),
        .done    (mul_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            acc_reg       <= 64'd0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= seed_value;
            end
            if (cmd.acc_init)
            begin
                acc_reg    <= {32'd0, seed_reg} ^ product;
                in_msg_reg <= 1'b1;
            end
            else if (cmd.acc_prod)
            begin
                acc_reg <= product;
            end
            if (cmd.out_load)
            begin
                in_msg_reg    <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            word_reg  <= data_word;
            count_reg <= byte_count;
            first_reg <= first_item;
            last_reg  <= last_item;
            len_reg   <= message_length;
        end
        if (cmd.out_load)
        begin
            hash_reg <= product ^ (product >> MIX_SHIFT);
        end
    end

    assign st.first      = first_reg;
    assign st.last       = last_reg;
    assign st.count_full = count_reg[3];      // 8 and above count as full
    assign st.count_zero = (count_reg == 4'd0);
    assign st.in_msg     = in_msg_reg;
    assign st.mul_idle   = mul_idle;
    assign st.mul_done   = mul_done;
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule
`default_nettype wire

// ===== sv/mh64_ctrl.sv =====
`default_nettype none
// ============================================================================
// mh64_ctrl
// Sequencer for one input beat: start, word mix, partial word, finalization.
// ============================================================================
module mh64_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mh64_pkg::mh_status_t st,
    output mh64_pkg::mh_cmd_t      cmd
);
    import mh64_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_INIT     = 10'b0000000100,
        S_DISPATCH = 10'b0000001000,
        S_MIX1     = 10'b0000010000,
        S_MIX2     = 10'b0000100000,
        S_MIX3     = 10'b0001000000,
        S_PART     = 10'b0010000000,
        S_TAIL     = 10'b0100000000,
        S_FIN      = 10'b1000000000
    } mh_state_t;

    mh_state_t state_reg, state_next;
    logic      emit_reg, emit_next;   // finalized hash waiting for output slot

    always_comb
    begin
        state_next    = state_reg;
        emit_next     = emit_reg;
        cmd.load_in   = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.opsel     = OP_LEN;
        cmd.acc_init  = 1'b0;
        cmd.acc_prod  = 1'b0;
        cmd.out_load  = 1'b0;
        in_ready      = (state_reg == S_IDLE) && !emit_reg;

        if (emit_reg)
        begin
            if (st.out_free)
            begin
                cmd.out_load = 1'b1;
                emit_next    = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (st.first)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.opsel     = OP_LEN;
                        state_next    = S_INIT;
                    end
                    else if (st.in_msg)
                    begin
                        state_next = S_DISPATCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;   // beat outside a message
                    end
                end
                S_INIT:
                begin
                    if (st.mul_done)
                    begin
                        cmd.acc_init = 1'b1;
                        state_next   = S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (st.count_full)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.opsel     = OP_WORD;
                        state_next    = S_MIX1;
                    end
                    else if (!st.count_zero)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.opsel     = OP_PART;
                        state_next    = S_PART;
                    end
                    else
                    begin
                        state_next = S_TAIL;
                    end
                end
                S_MIX1:
                begin
                    if (st.mul_done)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.opsel     = OP_KMIX;
                        state_next    = S_MIX2;
                    end
                end
                S_MIX2:
                begin
                    if (st.mul_done)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.opsel     = OP_ACCK;
                        state_next    = S_MIX3;
                    end
                end
                S_MIX3, S_PART:
                begin
                    if (st.mul_done)
                    begin
                        cmd.acc_prod = 1'b1;
                        state_next   = S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    if (st.last)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.opsel     = OP_FIN;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_FIN:
                begin
                    if (st.mul_done)
                    begin
                        // product holds until the output slot frees up
                        if (st.out_free)
                        begin
                            cmd.out_load = 1'b1;
                        end
                        else
                        begin
                            emit_next = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> st.mul_idle)
        else $error("multiply launched while busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("hash loaded over an untaken result");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        st.mul_done |-> (state_reg == S_INIT || state_reg == S_MIX1 ||
                         state_reg == S_MIX2 || state_reg == S_MIX3 ||
                         state_reg == S_PART || state_reg == S_FIN))
        else $error("multiply finished with no state waiting on it");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded");
`endif

endmodule
`default_nettype wire

// ===== sv/murmur2_64bit_hash.sv =====
`default_nettype none
// ============================================================================
// murmur2_64bit_hash
// Streaming MurmurHash64A over 64-bit little-endian message words.
// ============================================================================
// One beat is taken at a time, and the next only once the current one is
// through. The first beat adds the length multiply. A partial word's mix is
// one product where a full word needs three. A zero-count beat and a beat
// outside a message need no multiply of their own. The last beat adds the
// finalization multiply before the hash is loaded. The shared multiply unit
// forms each 64-bit product by the mix constant in three 32x32 passes.
// The hash sits in an output register; a new beat is taken while it waits,
// and the block only stalls if a second hash is ready before the first is
// taken. The seed write port is always ready and should be used while idle.
module murmur2_64bit_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        first_item,
    input  wire logic        last_item,
    input  wire logic [30:0] message_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      hash_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] seed_value
);
    import mh64_pkg::*;

    mh_cmd_t    cmd;
    mh_status_t st;

    assign cfg_ready = 1'b1;

    mh64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    mh64_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .first_item     (first_item),
        .last_item      (last_item),
        .message_length (message_length),
        .cfg_valid      (cfg_valid),
        .seed_value     (seed_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Feeds message words over a valid/ready channel, predicts every hash with
// a local model of the accumulator, and checks each hash beat in order.
// A short directed set is followed by seed sweeps and random traffic.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic [3:0] WORD_BYTES = 4'd8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first_item;
    logic        last_item;
    logic [30:0] message_length;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] hash_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] seed_value;

    // local copy of the hash state
    logic [31:0] cur_seed  = '0;
    logic [63:0] acc_state = '0;
    bit          msg_open  = 1'b0;

    logic [63:0] expected_hashes[$];
    logic [63:0] want_hash;
    int          error_count = 0;
    int          items_taken = 0;
    int          cycle_count = 0;

    // traffic shaping
    int          burst_left       = 0;
    bit          sender_idle_on   = 1'b0;
    bit          receiver_stall_on = 1'b0;
    logic [15:0] stall_tick       = '0;
    logic [15:0] ready_pattern    = 16'hffff;

    murmur2_64bit_hash i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .first_item     (first_item),
        .last_item      (last_item),
        .message_length (message_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .seed_value     (seed_value)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] mix_mul(input logic [63:0] x);
        return x * mh64_pkg::MIX_MUL;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [30:0] rand_len();
        logic [31:0] r;
        r = $urandom;
        return r[30:0];
    endfunction

    // one accepted beat: updates the local state, reports whether the beat
    // belonged to a message and whether it closes one with a hash
    function automatic void predict_hash_step(input logic [63:0] word,
                                              input logic [3:0] cnt,
                                              input logic first,
                                              input logic last,
                                              input logic [30:0] len,
                                              output bit taken,
                                              output bit has_hash,
                                              output logic [63:0] hash);
        logic [63:0] k;
        logic [63:0] mask;
        logic [63:0] h;
        taken    = 1'b0;
        has_hash = 1'b0;
        hash     = '0;
        if (first)
        begin
            acc_state = {32'd0, cur_seed} ^ mix_mul({33'd0, len});
            msg_open  = 1'b1;
        end
        if (!msg_open)
            return;
        taken = 1'b1;
        if (cnt >= WORD_BYTES)
        begin
            k = mix_mul(word);
            k = k ^ (k >> mh64_pkg::MIX_SHIFT);
            k = mix_mul(k);
            acc_state = mix_mul(acc_state ^ k);
        end
        else if (cnt != 4'd0)
        begin
            mask = (64'd1 << (8 * cnt)) - 64'd1;
            acc_state = mix_mul(acc_state ^ (word & mask));
        end
        if (last)
        begin
            h = acc_state ^ (acc_state >> mh64_pkg::MIX_SHIFT);
            h = mix_mul(h);
            h = h ^ (h >> mh64_pkg::MIX_SHIFT);
            hash     = h;
            has_hash = 1'b1;
            msg_open = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count = error_count + 1;
    endtask

    // receiver: with stalls on, ready steps through a 16-bit pattern, redrawn when the low byte of stall_tick wraps
    always @(negedge clk)
    begin
        stall_tick = stall_tick + 16'd1;
        if (stall_tick[7:0] == 8'd0)
        begin
            if ($urandom_range(0, 3) == 0)
                ready_pattern = 16'($urandom & $urandom & $urandom);
            else
                ready_pattern = 16'($urandom);
        end
        out_ready = receiver_stall_on ? ready_pattern[stall_tick[3:0]] : 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hashes.size() == 0)
                report_mismatch($sformatf("hash %h with none pending", hash_value));
            else
            begin
                want_hash = expected_hashes.pop_front();
                if (hash_value !== want_hash)
                    report_mismatch($sformatf("hash_value %h, want %h",
                                              hash_value, want_hash));
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_word(input logic [63:0] word, input int cnt, input bit first,
                             input bit last, input logic [30:0] len);
        bit taken;
        bit has_hash;
        logic [63:0] h;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if (sender_idle_on)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(0, 40)) @(negedge clk);
            end
        end
        burst_left     = burst_left - 1;
        data_word      = word;
        byte_count     = cnt[3:0];
        first_item     = first;
        last_item      = last;
        message_length = len;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_hash_step(word, cnt[3:0], first, last, len, taken, has_hash, h);
        if (taken)
            items_taken = items_taken + 1;
        if (has_hash)
            expected_hashes.push_back(h);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // all hashes out, plus room for a beat that yields none
    task automatic wait_quiet();
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        @(negedge clk);
        seed_value = s;
        cfg_valid  = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_seed = s;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_clean_message(input int nbytes, input logic [30:0] len_field);
        int nw;
        int cnt;
        nw = (nbytes + 7) / 8;
        if (nbytes == 0)
            send_word(rand_word(), 0, 1'b1, 1'b1, len_field);
        else
        begin
            for (int i = 0; i < nw; i++)
            begin
                cnt = (i == nw - 1) ? nbytes - 8 * i : 8;
                send_word(rand_word(), cnt, i == 0, i == nw - 1, len_field);
            end
        end
    endtask

    // odd counts, restarts, and sometimes no closing beat
    task automatic send_broken_message();
        int nw;
        bit first;
        bit last;
        nw = $urandom_range(1, 5);
        for (int i = 0; i < nw; i++)
        begin
            first = (i == 0) || ($urandom_range(0, 5) == 0);
            last  = (i == nw - 1) && ($urandom_range(0, 1) == 1);
            send_word(rand_word(), $urandom_range(0, 15), first, last, rand_len());
        end
    endtask

    task automatic test_directed_cases();
        sender_idle_on    = 1'b0;
        receiver_stall_on = 1'b0;
        write_seed(32'h0);
        // empty message
        send_word(64'h0, 0, 1'b1, 1'b1, 31'd0);
        // single full words at the data extremes
        send_word(64'hffff_ffff_ffff_ffff, 8, 1'b1, 1'b1, 31'd8);
        send_word(64'h0, 8, 1'b1, 1'b1, 31'd8);
        // one-beat messages with every partial count
        for (int n = 1; n < 8; n++)
            send_word(rand_word(), n, 1'b1, 1'b1, 31'(n));
        // counts above eight act as a full word
        send_word(rand_word(), 9, 1'b1, 1'b0, 31'd16);
        send_word(rand_word(), 15, 1'b0, 1'b1, 31'd16);
        // zero count and partial word mid-message
        send_word(rand_word(), 8, 1'b1, 1'b0, 31'd20);
        send_word(rand_word(), 0, 1'b0, 1'b0, 31'd20);
        send_word(rand_word(), 3, 1'b0, 1'b0, 31'd20);
        send_word(rand_word(), 8, 1'b0, 1'b1, 31'd20);
        // no message open: ignored
        send_word(rand_word(), 8, 1'b0, 1'b1, 31'd8);
        send_word(rand_word(), 5, 1'b0, 1'b0, 31'd8);
        // restart while a message is open
        send_word(rand_word(), 8, 1'b1, 1'b0, 31'd24);
        send_word(rand_word(), 8, 1'b1, 1'b0, 31'd16);
        send_word(rand_word(), 8, 1'b0, 1'b1, 31'd16);
        // largest length, not matching the data
        send_word(rand_word(), 8, 1'b1, 1'b1, 31'h7fff_ffff);
    endtask

    task automatic test_seed_extremes();
        logic [31:0] seeds[4];
        seeds = '{32'hffff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0};
        sender_idle_on    = 1'b1;
        receiver_stall_on = 1'b1;
        foreach (seeds[i])
        begin
            wait_quiet();
            write_seed(seeds[i]);
            send_word(64'hffff_ffff_ffff_ffff, 8, 1'b1, 1'b0, 31'd12);
            send_word(rand_word(), 4, 1'b0, 1'b1, 31'd12);
            send_word(64'h0, 0, 1'b1, 1'b1, 31'd0);
        end
    endtask

    task automatic test_random_traffic();
        int left_in_phase;
        int nbytes;
        int kind;
        int mode;
        logic [31:0] s;
        logic [30:0] len_field;
        left_in_phase = 0;
        items_taken   = 0;
        while (items_taken < RANDOM_ITEMS)
        begin
            if (left_in_phase == 0)
            begin
                wait_quiet();
                case ($urandom_range(0, 4))
                    0:       s = 32'h0;
                    1:       s = 32'hffff_ffff;
                    default: s = $urandom;
                endcase
                write_seed(s);
                mode = $urandom_range(0, 3);
                sender_idle_on    = mode[0];
                receiver_stall_on = mode[1];
                left_in_phase     = $urandom_range(20, 60);
            end
            left_in_phase = left_in_phase - 1;
            kind = $urandom_range(0, 19);
            if (kind == 0)
                send_word(rand_word(), $urandom_range(0, 15), 1'b0,
                          1'($urandom_range(0, 1)), rand_len());
            else if (kind <= 3)
                send_broken_message();
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    nbytes = $urandom_range(0, 160);
                else
                    nbytes = $urandom_range(0, 40);
                if ($urandom_range(0, 9) == 0)
                    len_field = rand_len();
                else
                    len_field = nbytes[30:0];
                send_clean_message(nbytes, len_field);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_word      = '0;
        byte_count     = '0;
        first_item     = 1'b0;
        last_item      = 1'b0;
        message_length = '0;
        cfg_valid      = 1'b0;
        seed_value     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_seed_extremes();
        test_random_traffic();

        wait_quiet();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mh64_pkg.sv
sv/mh64_mul.sv
sv/mh64_datapath.sv
sv/mh64_ctrl.sv
sv/murmur2_64bit_hash.sv
tb/tb_top.sv
